FILE: rtl/core/rhf_pkg.sv
`timescale 1ns / 1ps

package rhf_pkg;

  localparam int unsigned TimeW   = 14;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned AmpW    = 8;
  localparam int unsigned ProdW   = LevelW + TimeW;
  localparam int unsigned DivSteps = LevelW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0]    RiseReset  = 14'd200;
  localparam logic [TimeW-1:0]    HoldReset  = 14'd0;
  localparam logic [TimeW-1:0]    FallReset  = 14'd400;
  localparam logic [LevelW-1:0]   TakeLimit  = 12'd3276;
  localparam logic [ElapsedW-1:0] ElapsedMax = 16'hFFFF;
  // 1/17 as 241/4096, exact for 8-bit amplitudes
  localparam logic [AmpW-1:0]     Recip17    = 8'd241;

  localparam logic [CfgIdxW-1:0] CFG_RISE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALL = 2'd2;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_TRIGGER = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_HOLD = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic            kind;
    logic [AmpW-1:0] amplitude;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [1:0]        phase;
    logic              in_wave;
    logic              can_take_wave;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic mul;
    logic div_step;
    logic apply;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_stat_t;

endpackage

FILE: rtl/core/rise_hold_fall_envelope.sv
`timescale 1ns / 1ps
// channel   signals                               direction
// in        in_valid, in_stall, in_data           item in, stall out
// out       out_valid, out_stall, out_data        result out, stall in
// cfg       cfg_valid, cfg_ready, cfg_index,      register write in
//           cfg_data
//
// a trigger goes from accept straight to hand-off; a tick that ends in a ramp
// passes accept, evaluate, multiply, 12 restoring divide steps, apply and hand-off,
// other ticks accept, evaluate and hand-off; both ramps share the 12-step divider
// synchronous active-low reset restores the register defaults and idle state
// one transaction is in work at a time; a finished result waits in the
// output register while the next item is taken, out_stall holds it there

module rise_hold_fall_envelope
  import rhf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  rhf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/rhf_ctrl.sv
`timescale 1ns / 1ps

module rhf_ctrl
  import rhf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t        state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_kind == KIND_TRIGGER) ? ST_DONE : ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.need_div ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/rhf_datapath.sv
`timescale 1ns / 1ps

module rhf_datapath
  import rhf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_data,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  output out_item_t          out_data
);

  logic [TimeW-1:0]    rise_r, hold_r, fall_r;
  phase_t              phase_r;
  logic [ElapsedW-1:0] elapsed_r;
  logic [LevelW-1:0]   peak_r, level_r;
  logic                wave_r;

  logic [TimeW-1:0]    opnd_r, divisor_r;
  logic                fall_sel_r;
  logic [TimeW-1:0]    rem_r;
  logic [LevelW-1:0]   quo_r;
  out_item_t           out_r;

  logic                   rise_gt, hold_gt, fall_gt;
  logic signed [17:0]     dh, df;
  logic [16:0]            dfc;
  logic [ProdW-1:0]       prod;
  logic [TimeW+1:0]       trial;
  logic [AmpW+TimeW-1:0]  amp_frac;
  logic [LevelW-1:0]      peak_new;

  // elapsed offsets into hold and fall, fall offset clamped at zero
  assign dh      = signed'({2'b00, elapsed_r}) - signed'({4'b0000, rise_r});
  assign df      = dh - signed'({4'b0000, hold_r});
  assign dfc     = df[17] ? 17'd0 : df[16:0];
  assign rise_gt = ({2'b00, rise_r} > elapsed_r);
  assign hold_gt = (signed'({4'b0000, hold_r}) > dh);
  assign fall_gt = ({3'b000, fall_r} > dfc);

  assign stat.need_div = ((phase_r == PH_RISE) && rise_gt) ||
                         ((phase_r == PH_FALL) && fall_gt);

  // amp * 4095 / 255 = amp * 16 + amp / 17
  assign amp_frac = ({TimeW'(0), in_data.amplitude} * {TimeW'(0), Recip17});
  assign peak_new = {in_data.amplitude, 4'b0000} + LevelW'(amp_frac[AmpW+TimeW-1:12]);

  assign prod  = peak_r * opnd_r;
  assign trial = {1'b0, rem_r, quo_r[LevelW-1]} - {2'b00, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= RiseReset;
      hold_r <= HoldReset;
      fall_r <= FallReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RISE: rise_r <= cfg_data;
        CFG_HOLD: hold_r <= cfg_data;
        CFG_FALL: fall_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      peak_r    <= '0;
      level_r   <= '0;
      wave_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_data.kind == KIND_TRIGGER) begin
          peak_r    <= peak_new;
          elapsed_r <= '0;
          phase_r   <= PH_RISE;
          wave_r    <= 1'b1;
        end else if (elapsed_r != ElapsedMax) begin
          elapsed_r <= elapsed_r + 1'b1;
        end
      end
      if (cmd.eval) begin
        unique case (phase_r)
          PH_RISE: begin
            if (!rise_gt) begin
              level_r <= peak_r;
              phase_r <= PH_HOLD;
            end
          end
          PH_HOLD: begin
            if (hold_gt) begin
              level_r <= peak_r;
            end else begin
              phase_r <= PH_FALL;
            end
          end
          PH_FALL: begin
            if (!fall_gt) begin
              phase_r <= PH_IDLE;
              level_r <= '0;
              peak_r  <= '0;
              wave_r  <= 1'b0;
            end
          end
          PH_IDLE: begin
            peak_r <= '0;
            wave_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.apply) begin
        level_r <= fall_sel_r ? (peak_r - quo_r) : quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (phase_r == PH_FALL) begin
        opnd_r     <= dfc[TimeW-1:0];
        divisor_r  <= fall_r;
        fall_sel_r <= 1'b1;
      end else begin
        opnd_r     <= elapsed_r[TimeW-1:0];
        divisor_r  <= rise_r;
        fall_sel_r <= 1'b0;
      end
    end
    // product < divisor * 4096, so the top bits already sit below the divisor
    if (cmd.mul) begin
      rem_r <= prod[ProdW-1:LevelW];
      quo_r <= prod[LevelW-1:0];
    end else if (cmd.div_step) begin
      if (!trial[TimeW+1]) begin
        rem_r <= trial[TimeW-1:0];
        quo_r <= {quo_r[LevelW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[TimeW-2:0], quo_r[LevelW-1]};
        quo_r <= {quo_r[LevelW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_r.level         <= level_r;
      out_r.phase         <= phase_r;
      out_r.in_wave       <= wave_r;
      out_r.can_take_wave <= (peak_r <= TakeLimit);
    end
  end

  assign out_data = out_r;

endmodule

FILE: tb/rise_hold_fall_envelope_test.sv
`timescale 1ns / 1ps

module rise_hold_fall_envelope_test;
  import rhf_pkg::*;

  localparam int LevelMax    = 4095;
  localparam int AmpMax      = 255;
  localparam int LimitCycles = 3000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CFG_RISE;
  logic [TimeW-1:0]   cfg_data = '0;

  rise_hold_fall_envelope u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // envelope shadow state and register copies
  logic [TimeW-1:0]    rise_ms = RiseReset;
  logic [TimeW-1:0]    hold_ms = HoldReset;
  logic [TimeW-1:0]    fall_ms = FallReset;
  phase_t              env_phase = PH_IDLE;
  logic [ElapsedW-1:0] env_elapsed = '0;
  logic [LevelW-1:0]   env_peak = '0;
  logic [LevelW-1:0]   env_level = '0;
  logic                env_wave = 1'b0;

  out_item_t envelope_fifo[$];

  bit gaps_on = 1'b1;
  bit stall_enable = 1'b1;
  int hold_off_req = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_triggers = 0;
  int n_results = 0;
  int n_cfg_writes = 0;
  int cycle_count = 0;

  function automatic out_item_t envelope_next(input in_item_t item);
    int e;
    int d;
    out_item_t r;
    if (item.kind == KIND_TRIGGER) begin
      env_peak = LevelW'((int'(item.amplitude) * LevelMax) / AmpMax);
      env_elapsed = '0;
      env_phase = PH_RISE;
      env_wave = 1'b1;
    end else begin
      if (env_elapsed != ElapsedMax) env_elapsed = env_elapsed + 1'b1;
      e = int'(env_elapsed);
      case (env_phase)
        PH_RISE: begin
          if (int'(rise_ms) > e) begin
            env_level = LevelW'((int'(env_peak) * e) / int'(rise_ms));
          end else begin
            env_level = env_peak;
            env_phase = PH_HOLD;
          end
        end
        PH_HOLD: begin
          d = e - int'(rise_ms);
          if (int'(hold_ms) > d) env_level = env_peak;
          else env_phase = PH_FALL;
        end
        PH_FALL: begin
          d = e - int'(rise_ms) - int'(hold_ms);
          if (d < 0) d = 0;
          if (int'(fall_ms) > d) begin
            env_level = env_peak - LevelW'((int'(env_peak) * d) / int'(fall_ms));
          end else begin
            env_phase = PH_IDLE;
            env_level = '0;
            env_peak = '0;
            env_wave = 1'b0;
          end
        end
        default: begin
          env_peak = '0;
          env_wave = 1'b0;
        end
      endcase
    end
    r.level = env_level;
    r.phase = env_phase;
    r.in_wave = env_wave;
    r.can_take_wave = (env_peak <= TakeLimit);
    return r;
  endfunction

  // called at a falling edge; leaves valid high so back-to-back items stay seamless
  task automatic send_item(input logic kind, input logic [AmpW-1:0] amp);
    in_item_t item;
    item.kind = kind;
    item.amplitude = amp;
    if (gaps_on && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 20 : 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    envelope_fifo.push_back(envelope_next(item));
    n_items++;
    if (kind == KIND_TRIGGER) n_triggers++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (envelope_fifo.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RISE: rise_ms = val;
      CFG_HOLD: hold_ms = val;
      CFG_FALL: fall_ms = val;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TimeW-1:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 60) return TimeW'($urandom_range(0, 8));
    if (r < 85) return TimeW'($urandom_range(9, 40));
    if (r < 92) return '0;
    if (r < 96) return '1;
    return TimeW'($urandom_range(0, 16383));
  endfunction

  function automatic logic [AmpW-1:0] pick_amp();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 28) return AmpW'($urandom_range(204, 205));
    return AmpW'($urandom_range(0, AmpMax));
  endfunction

  // receiver side: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_off_req > 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = stall_enable && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (envelope_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: level=%0d phase=%0d wave=%0b take=%0b",
                   out_data.level, out_data.phase, out_data.in_wave, out_data.can_take_wave);
      end else begin
        want = envelope_fifo.pop_front();
        if (out_data.level !== want.level || out_data.phase !== want.phase ||
            out_data.in_wave !== want.in_wave ||
            out_data.can_take_wave !== want.can_take_wave) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected level=%0d phase=%0d wave=%0b take=%0b,",
                      " got level=%0d phase=%0d wave=%0b take=%0b"},
                     n_results, want.level, want.phase, want.in_wave, want.can_take_wave,
                     out_data.level, out_data.phase, out_data.in_wave, out_data.can_take_wave);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("FAIL rise_hold_fall_envelope");
      $finish;
    end
  end

  task automatic test_reset_wave();
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_TRIGGER, 8'd255);
    repeat (3) send_item(KIND_TICK, 8'h5A);
    write_reg(CFG_RISE, '0);
    send_item(KIND_TICK, 8'hA5);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
    write_reg(CFG_FALL, '0);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
  endtask

  task automatic test_amplitude_edges();
    write_reg(CFG_RISE, 14'd1);
    write_reg(CFG_HOLD, 14'd1);
    write_reg(CFG_FALL, 14'd2);
    send_item(KIND_TRIGGER, 8'd0);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TRIGGER, 8'd204);
    send_item(KIND_TICK, 8'h00);
    // restart in the middle of a wave
    send_item(KIND_TRIGGER, 8'd205);
    repeat (4) send_item(KIND_TICK, 8'h00);
    send_item(KIND_TRIGGER, 8'd255);
    send_item(KIND_TICK, 8'h00);
  endtask

  task automatic test_midwave_registers();
    write_reg(CFG_RISE, '1);
    write_reg(CFG_HOLD, '1);
    write_reg(CFG_FALL, '1);
    send_item(KIND_TRIGGER, 8'd255);
    repeat (2) send_item(KIND_TICK, 8'h00);
    write_reg(CFG_RISE, 14'd2);
    send_item(KIND_TICK, 8'h00);
    // hold difference goes negative, hold continues
    write_reg(CFG_RISE, '1);
    send_item(KIND_TICK, 8'h00);
    write_reg(CFG_RISE, '0);
    write_reg(CFG_HOLD, '0);
    send_item(KIND_TICK, 8'h00);
    // fall offset negative, clamps to the peak
    write_reg(CFG_HOLD, '1);
    send_item(KIND_TICK, 8'h00);
    write_reg(CFG_HOLD, '0);
    send_item(KIND_TICK, 8'h00);
  endtask

  task automatic test_receiver_hold_off();
    write_reg(CFG_RISE, 14'd3);
    write_reg(CFG_HOLD, 14'd2);
    write_reg(CFG_FALL, 14'd4);
    hold_off_req = 200;
    repeat (2) @(negedge clk);
    send_item(KIND_TRIGGER, pick_amp());
    repeat (30) send_item(KIND_TICK, AmpW'($urandom_range(0, AmpMax)));
  endtask

  task automatic test_random_waves();
    int first_item;
    int span;
    int ticks;
    int r;
    int k;
    first_item = n_items;
    while (n_items - first_item < 1000) begin
      gaps_on = !(n_items - first_item >= 350 && n_items - first_item < 650);
      stall_enable = gaps_on;
      if (n_items == first_item || $urandom_range(3) == 0) begin
        write_reg(CFG_RISE, pick_time());
        write_reg(CFG_HOLD, pick_time());
        write_reg(CFG_FALL, pick_time());
      end
      send_item(KIND_TRIGGER, pick_amp());
      span = int'(rise_ms) + int'(hold_ms) + int'(fall_ms) + 3;
      ticks = ($urandom_range(3) == 0) ? $urandom_range(0, span) : span;
      if (ticks > 60) ticks = $urandom_range(20, 60);
      for (int i = 0; i < ticks; i++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_item(KIND_TRIGGER, pick_amp());
        end else if (r < 9) begin
          k = $urandom_range(0, 2);
          write_reg((k == 0) ? CFG_RISE : (k == 1) ? CFG_HOLD : CFG_FALL, pick_time());
        end
        send_item(KIND_TICK, AmpW'($urandom_range(0, AmpMax)));
      end
    end
    gaps_on = 1'b1;
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_reset_wave();
    test_amplitude_edges();
    test_midwave_registers();
    test_receiver_hold_off();
    test_random_waves();
    wait_drained();
    repeat (20) @(negedge clk);
    mismatches += envelope_fifo.size();
    $display("sent %0d items (%0d wave starts) and checked %0d results", n_items, n_triggers,
             n_results);
    $display("%0d register writes, receiver hold-off and a no-idle stretch included, %0d mismatches",
             n_cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS rise_hold_fall_envelope");
    end else begin
      $display("FAIL rise_hold_fall_envelope");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rhf_pkg.sv
rtl/core/rhf_ctrl.sv
rtl/core/rhf_datapath.sv
rtl/core/rise_hold_fall_envelope.sv
tb/rise_hold_fall_envelope_test.sv
